// File: hw/rtl/lsrt_pkg.sv
// Shared types and constants for the load/store request tracker.
// Used by lsrt_lane, lsrt_table and load_store_request_tracker_core.
package lsrt_pkg;

	localparam int LANE_SLOTS = 4;
	localparam int LANE_W     = 2;
	localparam int ADDR_W     = 32;
	localparam int ID_W       = 16;
	localparam int TAG_W      = 4;
	localparam int TAG_LIMIT  = 16;
	localparam int REM_W      = 3;
	localparam int KIND_W     = 2;
	localparam int WORD_LSB   = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FENCE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSP   = 2'd3;

	localparam logic [KIND_W-1:0] OUT_REQ   = 2'd0;
	localparam logic [KIND_W-1:0] OUT_DONE  = 2'd1;
	localparam logic [KIND_W-1:0] OUT_RETRY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SHARED_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARED_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IO_LIMIT     = 2'd3;

	typedef struct packed {
		logic sh;
		logic nc;
		logic hit;
	} lane_info_t;

	typedef struct packed {
		logic              rsp_vld;
		logic [TAG_W-1:0]  rsp_tag;
		logic              alloc_vld;
		logic [REM_W-1:0]  alloc_rem;
		logic [ID_W-1:0]   alloc_id;
	} tbl_cmd_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [TAG_W-1:0]  free_tag;
		logic              rsp_done;
		logic [ID_W-1:0]   rsp_id;
		logic              empty_after;
	} tbl_stat_t;

endpackage

// File: hw/rtl/load_store_request_tracker_core.sv
// Load/store request tracker: per-lane address classification, pending tag table,
// one result item per cycle, unless held by res_stall, through a registered output stage.
// An accepted item is captured, evaluated in ST_EVAL, then emitted from ST_EMIT.
// item_stall holds off new input items until the current item's N results (0 to 5)
// have all moved through the single output register.
// Reset (arst_n low, asynchronous): table empty, no fence waiting, windows zero.
module load_store_request_tracker_core #(
	parameter int NUM_LANES     = 4,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lsrt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsrt_pkg::ADDR_W-1:0]       cfg_data,

	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [lsrt_pkg::KIND_W-1:0]       kind,
	input  logic [lsrt_pkg::LANE_SLOTS-1:0]   thread_mask,
	input  logic [lsrt_pkg::ADDR_W-1:0]       lane0_addr,
	input  logic [lsrt_pkg::ADDR_W-1:0]       lane1_addr,
	input  logic [lsrt_pkg::ADDR_W-1:0]       lane2_addr,
	input  logic [lsrt_pkg::ADDR_W-1:0]       lane3_addr,
	input  logic [lsrt_pkg::ID_W-1:0]         instr_id,
	input  logic [lsrt_pkg::TAG_W-1:0]        rsp_tag,

	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [lsrt_pkg::KIND_W-1:0]       out_kind,
	output logic [lsrt_pkg::LANE_W-1:0]       lane,
	output logic [lsrt_pkg::ADDR_W-1:0]       req_addr,
	output logic                              req_store,
	output logic                              req_uncached,
	output logic                              to_shared,
	output logic [lsrt_pkg::TAG_W-1:0]        req_tag,
	output logic [lsrt_pkg::ID_W-1:0]         done_id,
	output logic                              last
);

	localparam int SLOTS = lsrt_pkg::LANE_SLOTS;
	localparam int TAG_SLOTS = (PENDING_DEPTH < lsrt_pkg::TAG_LIMIT) ? PENDING_DEPTH
		: lsrt_pkg::TAG_LIMIT;
	localparam logic [SLOTS-1:0] LANE_MASK = SLOTS'((1 << NUM_LANES) - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_EMIT} state_t;

	state_t                           state_q;

	logic [lsrt_pkg::ADDR_W-1:0]      shared_base_q, shared_limit_q, io_base_q, io_limit_q;

	// captured input item
	logic [lsrt_pkg::KIND_W-1:0]      kind_s1;
	logic [SLOTS-1:0]                 mask_s1;
	logic [lsrt_pkg::ADDR_W-1:0]      addr_s1 [SLOTS];
	logic [lsrt_pkg::ID_W-1:0]        id_s1;
	logic [lsrt_pkg::TAG_W-1:0]       rtag_s1;

	// per-item results waiting to be emitted
	logic [SLOTS-1:0]                 pend_q;
	logic [SLOTS-1:0]                 sh_q, nc_q;
	logic                             wr_q;
	logic [lsrt_pkg::TAG_W-1:0]       tag_q;
	logic                             ta_q;
	logic [lsrt_pkg::KIND_W-1:0]      ta_kind_q;
	logic [lsrt_pkg::ID_W-1:0]        ta_id_q;
	logic                             tb_q;
	logic                             fence_q;
	logic [lsrt_pkg::ID_W-1:0]        fence_id_q;

	// output register
	logic                             res_valid_q;
	logic [lsrt_pkg::KIND_W-1:0]      out_kind_q;
	logic [lsrt_pkg::LANE_W-1:0]      lane_q;
	logic [lsrt_pkg::ADDR_W-1:0]      req_addr_q;
	logic                             req_store_q, nc_out_q, sh_out_q, last_q;
	logic [lsrt_pkg::TAG_W-1:0]       req_tag_q;
	logic [lsrt_pkg::ID_W-1:0]        done_id_q;

	lsrt_pkg::lane_info_t             info [SLOTS];
	lsrt_pkg::tbl_cmd_t               cmd;
	lsrt_pkg::tbl_stat_t              stat;

	logic                             dup;
	logic [lsrt_pkg::REM_W-1:0]       act_cnt;
	logic [SLOTS-1:0]                 ev_pend;
	logic                             ev_ta;
	logic [lsrt_pkg::KIND_W-1:0]      ev_ta_kind;
	logic [lsrt_pkg::ID_W-1:0]        ev_ta_id;
	logic                             ev_tb;
	logic                             ev_fence_set;

	logic [lsrt_pkg::LANE_W-1:0]      em_lane;
	logic [SLOTS-1:0]                 em_rest;
	logic                             em_last;
	logic                             adv;

	generate
		for (genvar l = 0; l < SLOTS; l++) begin : g_lane
			if (l < NUM_LANES) begin : g_on
				lsrt_lane u_lane (
					.addr         (addr_s1[l]),
					.addr0        (addr_s1[0]),
					.shared_base  (shared_base_q),
					.shared_limit (shared_limit_q),
					.io_base      (io_base_q),
					.io_limit     (io_limit_q),
					.info         (info[l])
				);
			end else begin : g_off
				assign info[l] = '0;
			end
		end
	endgenerate

	lsrt_table #(
		.DEPTH (TAG_SLOTS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// merge lane findings and decide what the item causes
	always_comb begin
		dup = mask_s1[0];
		act_cnt = '0;
		for (int l = 0; l < SLOTS; l++) begin
			act_cnt = act_cnt + lsrt_pkg::REM_W'(mask_s1[l]);
			if (l > 0 && mask_s1[l] && !info[l].hit) begin
				dup = 1'b0;
			end
		end

		cmd = '0;
		cmd.rsp_tag   = rtag_s1;
		cmd.alloc_id  = id_s1;
		cmd.alloc_rem = dup ? lsrt_pkg::REM_W'(1) : act_cnt;
		ev_pend      = '0;
		ev_ta        = 1'b0;
		ev_ta_kind   = lsrt_pkg::OUT_DONE;
		ev_ta_id     = id_s1;
		ev_tb        = 1'b0;
		ev_fence_set = 1'b0;

		if (kind_s1 == lsrt_pkg::KIND_RSP) begin
			cmd.rsp_vld = (state_q == ST_EVAL);
			ev_ta       = stat.rsp_done;
			ev_ta_id    = stat.rsp_id;
			ev_tb       = fence_q && stat.empty_after;
		end else if (fence_q || (kind_s1 != lsrt_pkg::KIND_FENCE && stat.full)) begin
			ev_ta      = 1'b1;
			ev_ta_kind = lsrt_pkg::OUT_RETRY;
			ev_ta_id   = '0;
		end else if (kind_s1 == lsrt_pkg::KIND_FENCE) begin
			ev_ta        = stat.empty;
			ev_fence_set = !stat.empty;
		end else if (mask_s1 == '0) begin
			ev_ta = 1'b1;
		end else begin
			ev_pend = dup ? SLOTS'(1) : mask_s1;
			if (kind_s1 == lsrt_pkg::KIND_STORE) begin
				ev_ta = 1'b1;
			end else begin
				cmd.alloc_vld = (state_q == ST_EVAL);
			end
		end
	end

	// pick the next result item: lane requests in lane order, then completions
	always_comb begin
		em_lane = '0;
		for (int l = SLOTS - 1; l >= 0; l--) begin
			if (pend_q[l]) begin
				em_lane = lsrt_pkg::LANE_W'(l);
			end
		end
		em_rest = pend_q;
		em_rest[em_lane] = 1'b0;
		if (pend_q != '0) begin
			em_last = (em_rest == '0) && !ta_q && !tb_q;
		end else if (ta_q) begin
			em_last = !tb_q;
		end else begin
			em_last = 1'b1;
		end
	end

	assign adv = !res_valid_q || !res_stall;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			kind_s1    <= kind;
			mask_s1    <= thread_mask & LANE_MASK;
			addr_s1[0] <= lane0_addr;
			addr_s1[1] <= lane1_addr;
			addr_s1[2] <= lane2_addr;
			addr_s1[3] <= lane3_addr;
			id_s1      <= instr_id;
			rtag_s1    <= rsp_tag;
		end
		if (state_q == ST_EVAL) begin
			for (int l = 0; l < SLOTS; l++) begin
				sh_q[l] <= info[l].sh;
				nc_q[l] <= info[l].nc;
			end
			wr_q      <= (kind_s1 == lsrt_pkg::KIND_STORE);
			tag_q     <= stat.free_tag;
			ta_kind_q <= ev_ta_kind;
			ta_id_q   <= ev_ta_id;
			if (ev_fence_set) begin
				fence_id_q <= id_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			shared_base_q  <= '0;
			shared_limit_q <= '0;
			io_base_q      <= '0;
			io_limit_q     <= '0;
			pend_q         <= '0;
			ta_q           <= 1'b0;
			tb_q           <= 1'b0;
			fence_q        <= 1'b0;
			res_valid_q    <= 1'b0;
			out_kind_q     <= '0;
			lane_q         <= '0;
			req_addr_q     <= '0;
			req_store_q    <= 1'b0;
			nc_out_q       <= 1'b0;
			sh_out_q       <= 1'b0;
			req_tag_q      <= '0;
			done_id_q      <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lsrt_pkg::CFG_SHARED_BASE:  shared_base_q  <= cfg_data;
					lsrt_pkg::CFG_SHARED_LIMIT: shared_limit_q <= cfg_data;
					lsrt_pkg::CFG_IO_BASE:      io_base_q      <= cfg_data;
					lsrt_pkg::CFG_IO_LIMIT:     io_limit_q     <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == ST_EMIT && adv) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					pend_q <= ev_pend;
					ta_q   <= ev_ta;
					tb_q   <= ev_tb;
					if (ev_fence_set) begin
						fence_q <= 1'b1;
					end else if (ev_tb) begin
						fence_q <= 1'b0;
					end
					state_q <= (ev_pend != '0 || ev_ta || ev_tb) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (adv) begin
						last_q <= em_last;
						if (pend_q != '0) begin
							out_kind_q  <= lsrt_pkg::OUT_REQ;
							lane_q      <= em_lane;
							req_addr_q  <= addr_s1[em_lane];
							req_store_q <= wr_q;
							nc_out_q    <= nc_q[em_lane];
							sh_out_q    <= sh_q[em_lane];
							req_tag_q   <= tag_q;
							done_id_q   <= '0;
							pend_q      <= em_rest;
						end else begin
							lane_q      <= '0;
							req_addr_q  <= '0;
							req_store_q <= 1'b0;
							nc_out_q    <= 1'b0;
							sh_out_q    <= 1'b0;
							req_tag_q   <= '0;
							if (ta_q) begin
								out_kind_q <= ta_kind_q;
								done_id_q  <= ta_id_q;
								ta_q       <= 1'b0;
							end else begin
								out_kind_q <= lsrt_pkg::OUT_DONE;
								done_id_q  <= fence_id_q;
								tb_q       <= 1'b0;
							end
						end
						if (em_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign res_valid    = res_valid_q;
	assign out_kind     = out_kind_q;
	assign lane         = lane_q;
	assign req_addr     = req_addr_q;
	assign req_store    = req_store_q;
	assign req_uncached = nc_out_q;
	assign to_shared    = sh_out_q;
	assign req_tag      = req_tag_q;
	assign done_id      = done_id_q;
	assign last         = last_q;

endmodule

// File: hw/rtl/lsrt_lane.sv
// One lane of the tracker: window classification and word match against lane 0.
// Depends on lsrt_pkg.
module lsrt_lane (
	input  logic [lsrt_pkg::ADDR_W-1:0] addr,
	input  logic [lsrt_pkg::ADDR_W-1:0] addr0,
	input  logic [lsrt_pkg::ADDR_W-1:0] shared_base,
	input  logic [lsrt_pkg::ADDR_W-1:0] shared_limit,
	input  logic [lsrt_pkg::ADDR_W-1:0] io_base,
	input  logic [lsrt_pkg::ADDR_W-1:0] io_limit,
	output lsrt_pkg::lane_info_t        info
);

	logic in_shared;
	logic in_io;

	assign in_shared = (addr >= shared_base) && (addr < shared_limit);
	assign in_io     = (addr >= io_base) && (addr < io_limit);

	// shared window wins over io
	assign info.sh  = in_shared;
	assign info.nc  = !in_shared && in_io;
	assign info.hit = addr[lsrt_pkg::ADDR_W-1:lsrt_pkg::WORD_LSB]
		== addr0[lsrt_pkg::ADDR_W-1:lsrt_pkg::WORD_LSB];

endmodule

// File: hw/rtl/lsrt_table.sv
// Pending request table: valid bits, response counters and instruction ids per tag.
// Depends on lsrt_pkg.
module lsrt_table #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsrt_pkg::tbl_cmd_t  cmd,
	output lsrt_pkg::tbl_stat_t stat
);

	localparam int TW = $clog2(DEPTH);

	logic [DEPTH-1:0]                valid_q;
	logic [lsrt_pkg::REM_W-1:0]      rem_q   [DEPTH];
	logic [lsrt_pkg::ID_W-1:0]       instr_q [DEPTH];

	logic [TW-1:0]                   idx;
	logic                            in_range;
	logic                            hit;
	logic [lsrt_pkg::REM_W-1:0]      rem_dec;
	logic                            rsp_done;
	logic [DEPTH-1:0]                clr_mask;
	logic [TW-1:0]                   free_idx;

	assign idx      = cmd.rsp_tag[TW-1:0];
	assign in_range = {1'b0, cmd.rsp_tag} < (lsrt_pkg::TAG_W + 1)'(DEPTH);
	assign hit      = in_range && valid_q[idx];
	assign rem_dec  = (rem_q[idx] != '0) ? rem_q[idx] - 1'b1 : rem_q[idx];
	assign rsp_done = hit && (rem_dec == '0);

	always_comb begin
		clr_mask = '0;
		free_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rsp_done && (idx == TW'(i))) begin
				clr_mask[i] = 1'b1;
			end
		end
		// lowest free tag wins
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = TW'(i);
			end
		end
	end

	assign stat.full        = &valid_q;
	assign stat.empty       = ~|valid_q;
	assign stat.free_tag    = lsrt_pkg::TAG_W'(free_idx);
	assign stat.rsp_done    = rsp_done;
	assign stat.rsp_id      = instr_q[idx];
	assign stat.empty_after = ~|(valid_q & ~clr_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.rsp_vld && rsp_done) begin
				valid_q[idx] <= 1'b0;
			end
			if (cmd.alloc_vld) begin
				valid_q[free_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_vld && hit) begin
			rem_q[idx] <= rem_dec;
		end
		if (cmd.alloc_vld) begin
			rem_q[free_idx]   <= cmd.alloc_rem;
			instr_q[free_idx] <= cmd.alloc_id;
		end
	end

endmodule
